// ===== design/two_level_free_class_search_core_macros.svh =====
// Assertion macros for the free-class search core.
// Used by the classmap, bitmap and top-level modules; clocked on clk_i, reset by rst_ni.
`ifndef TWO_LEVEL_FREE_CLASS_SEARCH_CORE_MACROS_SVH
`define TWO_LEVEL_FREE_CLASS_SEARCH_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TLFCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define TLFCS_NEVER(lbl, cond, msg) `TLFCS_ASSERT(lbl, !(cond), msg)
`else
`define TLFCS_ASSERT(lbl, prop, msg)
`define TLFCS_NEVER(lbl, cond, msg)
`endif
`endif

// ===== design/tlfcs_pkg.sv =====
// Shared types, constants and helper functions of the free-class search core.
// No dependencies; imported by every module of the block.
`default_nettype none

package tlfcs_pkg;

  localparam int unsigned SIZE_W       = 32;
  localparam int unsigned IDX_W        = 5;
  localparam int unsigned LIST_W       = 10;
  localparam int unsigned SLL_W        = 3;
  localparam int unsigned HDR_W        = 7;
  localparam int unsigned CFG_DATA_W   = 7;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned ROW_BITS     = 32;
  localparam int unsigned SLL_MAX      = 5;
  localparam int unsigned ROWS_MAX     = 32;
  localparam int unsigned MIN_BLOCK    = 32;
  localparam int unsigned SIZE_GRANULE = 4;

  // size + header + granule - 1 stays below 2^33
  localparam int unsigned T_W     = SIZE_W + 1;
  localparam int unsigned SHIFT_W = $clog2(T_W);
  localparam int unsigned NIBBLES = (T_W + 3) / 4;

  // remainder by the granule: nibble fold, then reciprocal on the folded value
  localparam int unsigned FOLD_W      = 12;
  localparam int unsigned RECIP_SHIFT = FOLD_W + 4;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned PROD_W      = FOLD_W + RECIP_W;
  localparam int unsigned GRAN_RECIP  = ((1 << RECIP_SHIFT) + SIZE_GRANULE - 1) / SIZE_GRANULE;

  // accept edge to the edge that takes the result
  localparam int unsigned PIPE_DEPTH = 7;

  typedef enum logic [1:0] {
    CMD_FIND   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLL    = 2'd0,
    CFG_ROWS   = 2'd1,
    CFG_HEADER = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [SLL_W-1:0]   sll;
    logic [SHIFT_W-1:0] rows;
    logic [HDR_W-1:0]   header;
  } cfg_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [SIZE_W-1:0] size;
    logic [IDX_W-1:0]  first_class;
    logic [IDX_W-1:0]  second_class;
  } item_t;

  typedef struct packed {
    item_t             item;
    logic              ovf;
    logic [SIZE_W-1:0] adjusted;
  } stage_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] fl;
    logic [IDX_W-1:0]   sl;
    logic               zero;
  } class_t;

  // 16^i mod granule for each nibble position
  function automatic logic [NIBBLES*4-1:0] nib_weights();
    logic [NIBBLES*4-1:0] w;
    int unsigned m;
    w = '0;
    m = 1 % SIZE_GRANULE;
    for (int i = 0; i < NIBBLES; i++) begin
      w[i*4 +: 4] = 4'(m);
      m = (m * 16) % SIZE_GRANULE;
    end
    return w;
  endfunction

  localparam logic [NIBBLES*4-1:0] NIB_WEIGHT = nib_weights();

  function automatic logic [SHIFT_W-1:0] msb_index(input logic [T_W-1:0] v);
    logic [SHIFT_W-1:0] n;
    n = '0;
    for (int i = 0; i < T_W; i++) begin
      if (v[i]) n = SHIFT_W'(i);
    end
    return n;
  endfunction

  function automatic logic [IDX_W-1:0] lsb_index(input logic [ROW_BITS-1:0] v);
    logic [IDX_W-1:0] n;
    n = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (v[i]) n = IDX_W'(i);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== design/tlfcs_adjust.sv =====
// Request size adjustment: header, minimum block and granule rounding, three stages.
// Depends on tlfcs_pkg.
`default_nettype none

module tlfcs_adjust import tlfcs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   in_valid_i,
  input  item_t  in_item_i,
  output logic   out_valid_o,
  output stage_t out_o
);

  logic              v1_q, v2_q, v3_q;
  item_t             it1_q, it2_q;
  logic [T_W-1:0]    t1_d, t1_q, t2_q;
  logic [FOLD_W-1:0] x2_d, x2_q;
  logic [T_W-1:0]    sum;
  logic [NIBBLES*4-1:0] tp;
  logic [PROD_W-1:0] prod;
  logic [FOLD_W-1:0] rem;
  logic [T_W-1:0]    s3;
  stage_t            st3_d, st3_q;

  // stage 1: add header, raise to minimum, add granule - 1
  always_comb begin
    sum  = T_W'(in_item_i.size) + T_W'(cfg_i.header);
    t1_d = ((sum < T_W'(MIN_BLOCK)) ? T_W'(MIN_BLOCK) : sum) + T_W'(SIZE_GRANULE - 1);
  end

  // stage 2: fold nibbles into a small value congruent modulo the granule
  always_comb begin
    tp   = (NIBBLES*4)'(t1_q);
    x2_d = '0;
    for (int i = 0; i < NIBBLES; i++) begin
      x2_d = x2_d + FOLD_W'(tp[i*4 +: 4]) * FOLD_W'(NIB_WEIGHT[i*4 +: 4]);
    end
  end

  // stage 3: exact remainder through the reciprocal, then round down
  always_comb begin
    prod = PROD_W'(x2_q) * PROD_W'(GRAN_RECIP);
    rem  = x2_q - FOLD_W'(prod[PROD_W-1:RECIP_SHIFT]) * FOLD_W'(SIZE_GRANULE);
    s3   = t2_q - T_W'(rem);
    st3_d.item     = it2_q;
    st3_d.ovf      = s3[T_W-1];
    st3_d.adjusted = s3[SIZE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    it1_q <= in_item_i;
    t1_q  <= t1_d;
    it2_q <= it1_q;
    t2_q  <= t1_q;
    x2_q  <= x2_d;
    st3_q <= st3_d;
  end

  assign out_valid_o = v3_q;
  assign out_o       = st3_q;

endmodule

`default_nettype wire

// ===== design/tlfcs_classmap.sv =====
// Size to class mapping: round-up to the next class for find, then first/second level split.
// Depends on tlfcs_pkg and the assertion macros.
`default_nettype none

`include "two_level_free_class_search_core_macros.svh"

module tlfcs_classmap import tlfcs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   in_valid_i,
  input  stage_t in_i,
  output logic   out_valid_o,
  output stage_t out_stage_o,
  output class_t out_map_o
);

  logic               v4_q, v5_q;
  stage_t             st4_q, st5_q;
  logic [T_W-1:0]     m4_d, m4_q;
  logic [T_W-1:0]     s_full;
  logic [SHIFT_W-1:0] f0;
  logic [SHIFT_W-1:0] f;
  logic [T_W-1:0]     rest;
  class_t             map5_d, map5_q;

  // stage 4: find rounds up to the start of the next class
  always_comb begin
    s_full = {in_i.ovf, in_i.adjusted};
    f0     = msb_index(s_full);
    if (in_i.item.cmd == CMD_FIND) begin
      m4_d = s_full + (T_W'(1) << (f0 - SHIFT_W'(cfg_i.sll))) - T_W'(1);
    end else begin
      m4_d = T_W'(in_i.item.size);
    end
  end

  // stage 5: leading one gives the row, the bits below it the class
  always_comb begin
    f    = msb_index(m4_q);
    rest = m4_q ^ (T_W'(1) << f);
    map5_d.fl   = f;
    map5_d.zero = (m4_q == '0);
    if (f >= SHIFT_W'(cfg_i.sll)) begin
      map5_d.sl = IDX_W'(rest >> (f - SHIFT_W'(cfg_i.sll)));
    end else begin
      map5_d.sl = IDX_W'(rest << (SHIFT_W'(cfg_i.sll) - f));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v4_q <= in_valid_i;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    st4_q  <= in_i;
    m4_q   <= m4_d;
    st5_q  <= st4_q;
    map5_q <= map5_d;
  end

  assign out_valid_o = v5_q;
  assign out_stage_o = st5_q;
  assign out_map_o   = map5_q;

  `TLFCS_ASSERT(a_map_in_row, v5_q && !map5_q.zero |-> (SHIFT_W'(map5_q.sl) < (SHIFT_W'(1) << cfg_i.sll)), "mapped class lies outside its row")

endmodule

`default_nettype wire

// ===== design/tlfcs_bitmap.sv =====
// Occupancy bitmaps, first-fit search, insert/clear update and the result register.
// Depends on tlfcs_pkg and the assertion macros.
`default_nettype none

`include "two_level_free_class_search_core_macros.svh"

module tlfcs_bitmap import tlfcs_pkg::*; #(
  parameter int unsigned NROWS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  input  stage_t             in_stage_i,
  input  class_t             in_map_i,
  output logic               done_o,
  output logic               found_o,
  output logic [IDX_W-1:0]   first_index_o,
  output logic [IDX_W-1:0]   second_index_o,
  output logic [LIST_W-1:0]  list_number_o,
  output logic [SIZE_W-1:0]  adjusted_size_o
);

  localparam int unsigned ROW_W = $clog2(NROWS);

  logic [NROWS-1:0]               row_d, row_q;
  logic [NROWS-1:0][ROW_BITS-1:0] class_d, class_q;
  logic [NROWS-1:0][ROW_BITS-1:0] masked;
  logic [NROWS-1:0]               cand;
  logic [SHIFT_W-1:0]             row_len;
  logic [ROW_BITS-1:0]            cmask;
  logic [ROW_BITS-1:0]            above;
  logic [ROW_W-1:0]               win;
  logic                           find_ok, ins_wr, clr_wr;
  logic                           found_d;
  logic [IDX_W-1:0]               fl_d, sl_d;
  logic [SIZE_W-1:0]              adj_d;

  logic                           done_q, found_q;
  logic [IDX_W-1:0]               fl_q, sl_q;
  logic [LIST_W-1:0]              list_q;
  logic [SIZE_W-1:0]              adj_q;

  always_comb begin
    row_len = SHIFT_W'(1) << cfg_i.sll;
    cmask   = {ROW_BITS{1'b1}} >> (SHIFT_W'(ROW_BITS) - row_len);
    above   = {ROW_BITS{1'b1}} << in_map_i.sl;
    find_ok = in_valid_i && (in_stage_i.item.cmd == CMD_FIND) && !in_stage_i.ovf &&
              (in_map_i.fl < cfg_i.rows);
    // a row qualifies only with its summary bit and a live class bit
    for (int r = 0; r < NROWS; r++) begin
      masked[r] = class_q[r] & cmask &
                  ((in_map_i.fl == SHIFT_W'(r)) ? above : {ROW_BITS{1'b1}});
      cand[r]   = find_ok && row_q[r] && (|masked[r]) &&
                  (SHIFT_W'(r) >= in_map_i.fl) && (SHIFT_W'(r) < cfg_i.rows);
    end
    win = '0;
    for (int r = NROWS - 1; r >= 0; r--) begin
      if (cand[r]) win = ROW_W'(r);
    end
    found_d = |cand;
  end

  always_comb begin
    fl_d  = '0;
    sl_d  = '0;
    adj_d = '0;
    unique case (in_stage_i.item.cmd)
      CMD_FIND: begin
        adj_d = in_stage_i.ovf ? {SIZE_W{1'b1}} : in_stage_i.adjusted;
        if (found_d) begin
          fl_d = IDX_W'(win);
          sl_d = lsb_index(masked[win]);
        end
      end
      CMD_INSERT: begin
        if (!in_map_i.zero) begin
          fl_d = IDX_W'(in_map_i.fl);
          sl_d = in_map_i.sl;
        end
      end
      CMD_CLEAR: begin
        fl_d = in_stage_i.item.first_class;
        sl_d = in_stage_i.item.second_class;
      end
      default: begin
        fl_d = '0;
      end
    endcase
  end

  // state update; row summary drops only when the masked row empties
  always_comb begin
    ins_wr  = in_valid_i && (in_stage_i.item.cmd == CMD_INSERT) && !in_map_i.zero &&
              (in_map_i.fl < cfg_i.rows);
    clr_wr  = in_valid_i && (in_stage_i.item.cmd == CMD_CLEAR) &&
              (SHIFT_W'(in_stage_i.item.first_class) < cfg_i.rows) &&
              (SHIFT_W'(in_stage_i.item.second_class) < row_len);
    class_d = class_q;
    row_d   = row_q;
    for (int r = 0; r < NROWS; r++) begin
      if (ins_wr && (in_map_i.fl == SHIFT_W'(r))) begin
        class_d[r][in_map_i.sl] = 1'b1;
        row_d[r]                = 1'b1;
      end
      if (clr_wr && (in_stage_i.item.first_class == IDX_W'(r))) begin
        class_d[r][in_stage_i.item.second_class] = 1'b0;
        row_d[r] = row_q[r] & (|(class_d[r] & cmask));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      class_q <= '0;
      done_q  <= 1'b0;
    end else begin
      row_q   <= row_d;
      class_q <= class_d;
      done_q  <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    fl_q    <= fl_d;
    sl_q    <= sl_d;
    list_q  <= LIST_W'((LIST_W'(fl_d) << cfg_i.sll) + LIST_W'(sl_d));
    adj_q   <= adj_d;
  end

  assign done_o          = done_q;
  assign found_o         = found_q;
  assign first_index_o   = fl_q;
  assign second_index_o  = sl_q;
  assign list_number_o   = list_q;
  assign adjusted_size_o = adj_q;

  `TLFCS_ASSERT(a_find_keeps_bitmap, in_valid_i && (in_stage_i.item.cmd == CMD_FIND) |=> $stable(row_q) && $stable(class_q), "find item changed the bitmaps")
  `TLFCS_ASSERT(a_found_in_rows, done_q && found_q |-> (SHIFT_W'(fl_q) < cfg_i.rows), "fit reported in a row beyond the usable rows")
  `TLFCS_NEVER(a_found_needs_find, in_valid_i && found_d && (in_stage_i.item.cmd != CMD_FIND), "fit raised for a non-find item")

endmodule

`default_nettype wire

// ===== design/two_level_free_class_search_core.sv =====
// Top level of the two-level free-class search core: input register, configuration
// registers, size adjustment, class mapping and bitmap stages. Depends on tlfcs_pkg.
//
// The core accepts one item in every cycle; busy never rises and the configuration
// port is always ready. Each item gives exactly one result, shown on the result
// ports for one cycle with done_o high. Results come out in item order and cannot
// be held off, so the receiver must take every strobe. Each item passes through the
// pipeline stages in order: input register, header and minimum add, granule
// remainder fold, reciprocal rounding, next-class round-up, class split, and the
// bitmap search with its result register. Insert and clear update the bitmaps in
// the last stage, so a later find always sees them.
`default_nettype none

`include "two_level_free_class_search_core_macros.svh"

module two_level_free_class_search_core import tlfcs_pkg::*; #(
  parameter int unsigned FIRST_LEVELS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            command_i,
  input  logic [SIZE_W-1:0]     request_size_i,
  input  logic [IDX_W-1:0]      first_class_i,
  input  logic [IDX_W-1:0]      second_class_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  done_o,
  output logic                  found_o,
  output logic [IDX_W-1:0]      first_index_o,
  output logic [IDX_W-1:0]      second_index_o,
  output logic [LIST_W-1:0]     list_number_o,
  output logic [SIZE_W-1:0]     adjusted_size_o
);

  // rows beyond the 32nd can never be used
  localparam int unsigned NROWS = (FIRST_LEVELS < ROWS_MAX) ? FIRST_LEVELS : ROWS_MAX;

  logic               in_accept;
  logic               in_valid_q;
  item_t              in_item_d, in_item_q;
  logic [SLL_W-1:0]   sll_q;
  logic [SHIFT_W-1:0] rows_q;
  logic [HDR_W-1:0]   hdr_q;
  cfg_t               cfg;
  logic               adj_valid, map_valid;
  stage_t             adj_stage, map_stage;
  class_t             map_class;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign in_accept   = start && !busy;

  always_comb begin
    in_item_d.cmd          = cmd_e'(command_i);
    in_item_d.size         = request_size_i;
    in_item_d.first_class  = first_class_i;
    in_item_d.second_class = second_class_i;
    cfg.sll    = (sll_q > SLL_W'(SLL_MAX)) ? SLL_W'(SLL_MAX) : sll_q;
    cfg.rows   = (rows_q > SHIFT_W'(NROWS)) ? SHIFT_W'(NROWS) : rows_q;
    cfg.header = hdr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      sll_q      <= SLL_W'(4);
      rows_q     <= SHIFT_W'(32);
      hdr_q      <= HDR_W'(16);
    end else begin
      in_valid_q <= in_accept;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_SLL:    sll_q  <= cfg_data_i[SLL_W-1:0];
          CFG_ROWS:   rows_q <= cfg_data_i[SHIFT_W-1:0];
          CFG_HEADER: hdr_q  <= cfg_data_i[HDR_W-1:0];
          default: begin
            sll_q <= sll_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_item_d;
    end
  end

  tlfcs_adjust u_adjust (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_q),
    .in_item_i   (in_item_q),
    .out_valid_o (adj_valid),
    .out_o       (adj_stage)
  );

  tlfcs_classmap u_classmap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (adj_valid),
    .in_i        (adj_stage),
    .out_valid_o (map_valid),
    .out_stage_o (map_stage),
    .out_map_o   (map_class)
  );

  tlfcs_bitmap #(
    .NROWS (NROWS)
  ) u_bitmap (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (map_valid),
    .in_stage_i      (map_stage),
    .in_map_i        (map_class),
    .done_o          (done_o),
    .found_o         (found_o),
    .first_index_o   (first_index_o),
    .second_index_o  (second_index_o),
    .list_number_o   (list_number_o),
    .adjusted_size_o (adjusted_size_o)
  );

  `TLFCS_ASSERT(a_result_after_latency, in_accept |-> ##PIPE_DEPTH done_o, "accepted item gave no result")
  `TLFCS_ASSERT(a_result_has_item, done_o |-> $past(in_accept, PIPE_DEPTH), "result without an accepted item")

endmodule

`default_nettype wire

// ===== tb/two_level_free_class_search_core_checker.sv =====
// Scoreboard for the free-class search core: watches the item, register and result channels,
// keeps its own copy of the occupancy bitmaps and compares every result field by field.
// Depends on tlfcs_pkg for widths and codes.
`default_nettype none

module two_level_free_class_search_core_checker import tlfcs_pkg::*; #(
  parameter int unsigned FIRST_LEVELS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  logic [1:0]            command_i,
  input  logic [SIZE_W-1:0]     request_size_i,
  input  logic [IDX_W-1:0]      first_class_i,
  input  logic [IDX_W-1:0]      second_class_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  done_i,
  input  logic                  found_i,
  input  logic [IDX_W-1:0]      first_index_i,
  input  logic [IDX_W-1:0]      second_index_i,
  input  logic [LIST_W-1:0]     list_number_i,
  input  logic [SIZE_W-1:0]     adjusted_size_i,
  output int                    fail_count_o,
  output int                    outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  first;
    logic [IDX_W-1:0]  second;
    logic [LIST_W-1:0] list;
    logic [SIZE_W-1:0] adjusted;
  } search_result_t;

  logic [SLL_W-1:0]    sll_reg;
  logic [5:0]          rows_reg;
  logic [HDR_W-1:0]    header_reg;
  logic [31:0]         row_summary;
  logic [31:0]         class_bits [32];
  search_result_t      expected_results [$];
  int                  mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic int unsigned msb_pos(input logic [63:0] v);
    int unsigned n;
    n = 0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = i;
    end
    return n;
  endfunction

  function automatic int unsigned lsb_pos(input logic [31:0] v);
    int unsigned n;
    n = 0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) n = i;
    end
    return n;
  endfunction

  // size to (row, class); small rows shift the tail bits left
  function automatic void split_size(input logic [63:0] s, input int unsigned sll,
                                     output int unsigned fl, output int unsigned sl);
    int unsigned f;
    logic [63:0] rest;
    f = msb_pos(s);
    rest = s ^ (64'd1 << f);
    fl = f;
    if (f >= sll) sl = 32'(rest >> (f - sll));
    else sl = 32'(rest << (sll - f));
  endfunction

  function automatic search_result_t apply_command(input cmd_e cmd, input logic [31:0] size,
                                                   input logic [4:0] fc,
                                                   input logic [4:0] sc);
    int unsigned sll, rows, f0, rf, rs, fl, sl;
    logic [31:0] cmask, here, bits;
    logic [63:0] s, r;
    logic hit;
    logic [31:0] adj;
    search_result_t res;
    sll = (sll_reg > SLL_MAX) ? SLL_MAX : sll_reg;
    rows = (rows_reg > ROWS_MAX) ? ROWS_MAX : rows_reg;
    if (rows > FIRST_LEVELS) rows = FIRST_LEVELS;
    cmask = 32'((64'd1 << (1 << sll)) - 64'd1);
    fl = 0;
    sl = 0;
    hit = 1'b0;
    adj = '0;
    case (cmd)
      CMD_FIND: begin
        s = 64'(size) + 64'(header_reg);
        if (s < 64'(MIN_BLOCK)) s = 64'(MIN_BLOCK);
        s = ((s + 64'(SIZE_GRANULE) - 64'd1) / 64'(SIZE_GRANULE)) * 64'(SIZE_GRANULE);
        if (s > 64'hFFFF_FFFF) begin
          adj = '1;
        end else begin
          adj = s[31:0];
          f0 = msb_pos(s);
          r = s;
          if (f0 >= sll) r = s + (64'd1 << (f0 - sll)) - 64'd1;
          split_size(r, sll, rf, rs);
          if (rf < rows) begin
            here = class_bits[rf] & cmask & ~32'((64'd1 << rs) - 64'd1);
            if (row_summary[rf] && here != 0) begin
              hit = 1'b1;
              fl = rf;
              sl = lsb_pos(here);
            end else begin
              for (int unsigned k = rf + 1; k < rows; k++) begin
                bits = class_bits[k] & cmask;
                if (row_summary[k] && bits != 0) begin
                  hit = 1'b1;
                  fl = k;
                  sl = lsb_pos(bits);
                  break;
                end
              end
            end
          end
        end
      end
      CMD_INSERT: begin
        if (size != 0) begin
          split_size(64'(size), sll, fl, sl);
          if (fl < rows) begin
            row_summary[fl] = 1'b1;
            class_bits[fl][sl] = 1'b1;
          end
        end
      end
      CMD_CLEAR: begin
        fl = fc;
        sl = sc;
        if (fl < rows && sl < (1 << sll)) begin
          class_bits[fl][sl] = 1'b0;
          if ((class_bits[fl] & cmask) == 0) row_summary[fl] = 1'b0;
        end
      end
      default: ;
    endcase
    res.found = hit;
    res.first = IDX_W'(fl);
    res.second = IDX_W'(sl);
    res.list = LIST_W'((32'(fl & 31) << sll) + 32'(sl & 31));
    res.adjusted = adj;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    search_result_t exp_r;
    if (!rst_ni) begin
      sll_reg = 3'd4;
      rows_reg = 6'd32;
      header_reg = 7'd16;
      row_summary = '0;
      for (int i = 0; i < 32; i++) class_bits[i] = '0;
      expected_results.delete();
      outstanding_o = 0;
    end else begin
      if (done_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding");
          mismatches++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("found", 32'(exp_r.found), 32'(found_i));
          check_field("first_index", 32'(exp_r.first), 32'(first_index_i));
          check_field("second_index", 32'(exp_r.second), 32'(second_index_i));
          check_field("list_number", 32'(exp_r.list), 32'(list_number_i));
          check_field("adjusted_size", exp_r.adjusted, adjusted_size_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_SLL:    sll_reg = cfg_data_i[SLL_W-1:0];
          CFG_ROWS:   rows_reg = cfg_data_i[5:0];
          CFG_HEADER: header_reg = cfg_data_i[HDR_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        expected_results.push_back(apply_command(cmd_e'(command_i), request_size_i,
                                                 first_class_i, second_class_i));
      end
      outstanding_o = expected_results.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/two_level_free_class_search_core_tb.sv =====
// Top of the free-class search testbench: clock, reset, register writes and command stimulus.
// Needs tlfcs_pkg, the core and two_level_free_class_search_core_checker.
`default_nettype none

module two_level_free_class_search_core_tb import tlfcs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 20;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = PIPE_DEPTH + 4;
  localparam int PHASE_ITEMS   = 150;
  localparam int NUM_PHASES    = 9;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [1:0]            command_i;
  logic [SIZE_W-1:0]     request_size_i;
  logic [IDX_W-1:0]      first_class_i;
  logic [IDX_W-1:0]      second_class_i;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  done_o;
  logic                  found_o;
  logic [IDX_W-1:0]      first_index_o;
  logic [IDX_W-1:0]      second_index_o;
  logic [LIST_W-1:0]     list_number_o;
  logic [SIZE_W-1:0]     adjusted_size_o;

  int fail_count;
  int outstanding;
  int cycles = 0;
  int items_sent = 0;
  int settings_used = 1;
  int cmd_count [4] = '{0, 0, 0, 0};
  int unsigned cur_sll = 4;
  int unsigned cur_rows = 32;

  // sll data values: 7'h7E has spare high bits set, keeps 6 and so clamps to 5
  logic [6:0] phase_sll  [NUM_PHASES] = '{7'd0, 7'd5, 7'd7, 7'd1, 7'd2, 7'd3, 7'h7E, 7'd4, 7'd5};
  logic [6:0] phase_rows [NUM_PHASES] = '{7'd1, 7'd32, 7'd63, 7'h48, 7'd0, 7'd20, 7'd45, 7'd32,
                                          7'd17};
  logic [6:0] phase_hdr  [NUM_PHASES] = '{7'd0, 7'd64, 7'd127, 7'd3, 7'd33, 7'd1, 7'd100, 7'd16,
                                          7'd7};

  two_level_free_class_search_core #(.FIRST_LEVELS(32)) dut (
    .clk_i, .rst_ni, .start, .busy, .command_i, .request_size_i, .first_class_i,
    .second_class_i, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i, .done_o,
    .found_o, .first_index_o, .second_index_o, .list_number_o, .adjusted_size_o
  );

  two_level_free_class_search_core_checker #(.FIRST_LEVELS(32)) u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .command_i, .request_size_i,
    .first_class_i, .second_class_i, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .done_i(done_o), .found_i(found_o), .first_index_i(first_index_o),
    .second_index_i(second_index_o), .list_number_i(list_number_o),
    .adjusted_size_i(adjusted_size_o), .fail_count_o(fail_count), .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // idle cycle with noise on the item fields
  task automatic drive_idle();
    @(negedge clk_i);
    start <= 1'b0;
    command_i <= 2'($urandom);
    request_size_i <= $urandom;
    first_class_i <= 5'($urandom);
    second_class_i <= 5'($urandom);
  endtask

  task automatic issue(input cmd_e c, input logic [31:0] sz, input logic [4:0] fc,
                       input logic [4:0] sc);
    @(negedge clk_i);
    start <= 1'b1;
    command_i <= c;
    request_size_i <= sz;
    first_class_i <= fc;
    second_class_i <= sc;
    do @(posedge clk_i); while (busy);
    items_sent++;
    cmd_count[int'(c)]++;
  endtask

  task automatic drain();
    drive_idle();
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [6:0] val);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_SLL:  cur_sll = val & 7;
      CFG_ROWS: cur_rows = val & 63;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] random_size();
    int unsigned k;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'hFFFF_FFFF - $urandom_range(0, 200);
      2: return $urandom_range(0, 3);
      default: begin
        // spread over every row
        k = $urandom_range(0, 31);
        return (32'd1 << k) | ($urandom & ((32'd1 << k) - 32'd1));
      end
    endcase
  endfunction

  task automatic random_item();
    int unsigned pick, sll_eff, rows_eff;
    logic [4:0] fc, sc;
    pick = $urandom_range(0, 99);
    sll_eff = (cur_sll > 5) ? 5 : cur_sll;
    rows_eff = (cur_rows > 32) ? 32 : cur_rows;
    if (pick < 40) begin
      issue(CMD_FIND, random_size(), 5'($urandom), 5'($urandom));
    end else if (pick < 75) begin
      issue(CMD_INSERT, random_size(), 5'($urandom), 5'($urandom));
    end else if (pick < 95) begin
      // mostly aim at a real list so rows do empty
      if (rows_eff != 0 && $urandom_range(0, 4) != 0) begin
        fc = 5'($urandom_range(0, rows_eff - 1));
        sc = 5'($urandom_range(0, (1 << sll_eff) - 1));
      end else begin
        fc = 5'($urandom);
        sc = 5'($urandom);
      end
      issue(CMD_CLEAR, $urandom, fc, sc);
    end else begin
      issue(CMD_NOP, $urandom, 5'($urandom), 5'($urandom));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    command_i = CMD_NOP;
    request_size_i = '0;
    first_class_i = '0;
    second_class_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_SLL;
    cfg_data_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part under the reset settings
    issue(CMD_FIND, 32'd1, '0, '0);
    issue(CMD_FIND, 32'd0, '0, '0);
    issue(CMD_FIND, 32'hFFFF_FFFF, '0, '0);
    issue(CMD_FIND, 32'hFFFF_FFF0, '0, '0);
    issue(CMD_FIND, 32'hFFFF_FFEC, '0, '0);
    issue(CMD_INSERT, 32'd0, '0, '0);
    issue(CMD_INSERT, 32'd1, '0, '0);
    issue(CMD_INSERT, 32'd100, '0, '0);
    issue(CMD_INSERT, 32'hFFFF_FFFF, '0, '0);
    issue(CMD_INSERT, 32'h8000_0000, '0, '0);
    issue(CMD_FIND, 32'd1, '0, '0);
    issue(CMD_FIND, 32'd60, '0, '0);
    issue(CMD_FIND, 32'd200, '0, '0);
    issue(CMD_CLEAR, '0, 5'd31, 5'd31);
    issue(CMD_CLEAR, '0, 5'd6, 5'd9);
    issue(CMD_CLEAR, '0, 5'd0, 5'd0);
    issue(CMD_FIND, 32'd60, '0, '0);
    issue(CMD_NOP, 32'hFFFF_FFFF, 5'd31, 5'd31);
    issue(CMD_FIND, 32'd2000, '0, '0);
    issue(CMD_CLEAR, '0, 5'd31, 5'd15);
    issue(CMD_CLEAR, '0, 5'd31, 5'd0);
    issue(CMD_FIND, 32'd1000, '0, '0);
    issue(CMD_INSERT, 32'h0000_1000, '0, '0);
    issue(CMD_FIND, 32'h0000_0FF0, '0, '0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_SLL, phase_sll[p]);
      write_reg(CFG_ROWS, phase_rows[p]);
      write_reg(CFG_HEADER, phase_hdr[p]);
      settings_used++;
      for (int n = 0; n < PHASE_ITEMS; ) begin
        int burst;
        burst = $urandom_range(1, 20);
        repeat (burst) random_item();
        n += burst;
        if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 6)) drive_idle();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    $display("tb: %0d items sent (%0d find, %0d insert, %0d clear, %0d no-op)",
             items_sent, cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3]);
    $display("tb: %0d register settings, including row counts of zero and above the bound",
             settings_used);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
